// ===== sv/bpa_pkg.sv =====
// Package for the bitmap page allocator: geometry, codes, state encoding,
// map port request type and saturating count helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    // Bitmap geometry
    localparam int PAGES      = 4096;
    localparam int PAGE_W     = $clog2(PAGES);
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORDS      = PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int CHUNK_BITS = 8;
    localparam int CHUNK_AW   = $clog2(WORD_BITS / CHUNK_BITS);

    // Field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 24;
    localparam int LEN_W    = 25;
    localparam int OFS_W    = 12;
    localparam int NPG_W    = LEN_W - OFS_W + 1;
    localparam int COUNT_W  = 13;
    localparam int RUN_W    = PAGE_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ADD     = 2'd2,
        OP_RESERVE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_NO_RUN     = 2'd2,
        ST_BOUNDS     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] wr_data;
    } t_map_req;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [NPG_W-1:0] b);
        logic [NPG_W:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] a,
                                                   input logic [NPG_W-1:0] b);
        return (b >= {1'b0, a}) ? '0 : a - b[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/bpa_map.sv =====
// Page bitmap storage: one memory word per 64 pages, per-word valid bits.
// A word never written reads as all used. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_map (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpa_pkg::t_map_req             i_req,
    output logic [bpa_pkg::WORD_BITS-1:0]      o_rd_word
);

    logic [bpa_pkg::WORD_BITS-1:0] r_mem [bpa_pkg::WORDS];
    logic [bpa_pkg::WORDS-1:0]     r_vld;
    logic [bpa_pkg::WORD_BITS-1:0] r_rd_data;
    logic                          r_rd_vld;

    // Write and read the memory array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // Track written words; reset leaves every page used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_data : '1;

endmodule
`default_nettype wire

// ===== sv/bpa_scan.sv =====
// First-fit run tracker: advances the free-run search across one 8-page chunk.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_scan (
    input  wire logic [bpa_pkg::CHUNK_BITS-1:0] i_used,
    input  wire logic [bpa_pkg::PAGE_W-1:0]     i_base,
    input  wire logic [bpa_pkg::RUN_W-1:0]      i_run,
    input  wire logic [bpa_pkg::PAGE_W-1:0]     i_start,
    input  wire logic [bpa_pkg::NPG_W-1:0]      i_pages,
    output logic [bpa_pkg::RUN_W-1:0]           o_run,
    output logic [bpa_pkg::PAGE_W-1:0]          o_start,
    output logic                                o_found
);

    localparam int LOW_W = $clog2(bpa_pkg::CHUNK_BITS);

    // Walk the chunk low page first; stop once the run is long enough
    always_comb begin
        logic [bpa_pkg::RUN_W-1:0]  run;
        logic [bpa_pkg::PAGE_W-1:0] start;
        logic                       found;
        run   = i_run;
        start = i_start;
        found = 1'b0;
        for (int b = 0; b < bpa_pkg::CHUNK_BITS; b++) begin
            if (!found) begin
                if (!i_used[b]) begin
                    if (run == '0) begin
                        start = {i_base[bpa_pkg::PAGE_W-1:LOW_W], LOW_W'(b)};
                    end
                    run = run + 1'b1;
                    if ({{(bpa_pkg::NPG_W-bpa_pkg::RUN_W){1'b0}}, run} == i_pages) begin
                        found = 1'b1;
                    end
                end else begin
                    run = '0;
                end
            end
        end
        o_run   = run;
        o_start = start;
        o_found = found;
    end

endmodule
`default_nettype wire

// ===== sv/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap page allocator: request sequencer, page counts,
// result register. Depends on bpa_pkg, bpa_map, bpa_scan.
//
//   channel  | direction | handshake                  | payload
//   request  | in        | i_in_valid / o_in_ready    | i_opcode, i_address, i_length_bytes
//   result   | out       | o_out_valid / i_out_ready  | o_status, o_result_address,
//            |           |                            | o_free_pages, o_used_pages, o_total_pages
//
// One request at a time. Allocate scans 8 pages a cycle, with a map read before each word
// of 64 pages, then marks each word of the run with a read and a write. Free, add and
// reserve read and write each bitmap word in the range, then load the result.
// A waiting result holds the sequencer in its last state until taken.
// Reset (synchronous) marks every page used and zeroes the counts.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [bpa_pkg::OP_W-1:0]        i_opcode,
    input  wire logic [bpa_pkg::ADDR_W-1:0]      i_address,
    input  wire logic [bpa_pkg::LEN_W-1:0]       i_length_bytes,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [bpa_pkg::ADDR_W-1:0]           o_result_address,
    output logic [bpa_pkg::COUNT_W-1:0]          o_free_pages,
    output logic [bpa_pkg::COUNT_W-1:0]          o_used_pages,
    output logic [bpa_pkg::COUNT_W-1:0]          o_total_pages
);

    localparam int PW = bpa_pkg::PAGE_W;

    bpa_pkg::t_state                r_state, n_state;
    bpa_pkg::t_opcode               r_op, n_op;
    bpa_pkg::t_status               r_status, n_status;
    logic                           r_apply, n_apply;
    logic [bpa_pkg::NPG_W-1:0]      r_pages, n_pages;
    logic [PW-1:0]                  r_base, n_base;
    logic [bpa_pkg::WORD_AW-1:0]    r_word, n_word;
    logic [bpa_pkg::CHUNK_AW-1:0]   r_chunk, n_chunk;
    logic [bpa_pkg::RUN_W-1:0]      r_run, n_run;
    logic [PW-1:0]                  r_start, n_start;
    logic [bpa_pkg::COUNT_W-1:0]    r_free, n_free;
    logic [bpa_pkg::COUNT_W-1:0]    r_used, n_used;
    logic [bpa_pkg::COUNT_W-1:0]    r_total, n_total;
    logic                           r_out_valid, n_out_valid;
    logic [1:0]                     r_out_status, n_out_status;
    logic [bpa_pkg::ADDR_W-1:0]     r_out_addr, n_out_addr;

    bpa_pkg::t_map_req              map_req;
    logic [bpa_pkg::WORD_BITS-1:0]  rd_word;
    logic [bpa_pkg::CHUNK_BITS-1:0] scan_used;
    logic [bpa_pkg::RUN_W-1:0]      scan_run;
    logic [PW-1:0]                  scan_start;
    logic                           scan_found;
    logic [bpa_pkg::NPG_W-1:0]      in_pages;
    logic [bpa_pkg::NPG_W:0]        in_end;
    logic [PW-1:0]                  last_page;
    logic [bpa_pkg::BIT_W:0]        lo_bit, hi_bit;
    logic [bpa_pkg::WORD_BITS-1:0]  mark_mask;

    bpa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_word (rd_word)
    );

    assign scan_used = rd_word[{r_chunk, {bpa_pkg::CHUNK_AW{1'b0}}} +: bpa_pkg::CHUNK_BITS];

    bpa_scan u_scan (
        .i_used  (scan_used),
        .i_base  ({r_word, r_chunk, {bpa_pkg::CHUNK_AW{1'b0}}}),
        .i_run   (r_run),
        .i_start (r_start),
        .i_pages (r_pages),
        .o_run   (scan_run),
        .o_start (scan_start),
        .o_found (scan_found)
    );

    // Round the request length up to whole pages; find the range end
    assign in_pages = bpa_pkg::NPG_W'(({1'b0, i_length_bytes} + 26'(12'hfff)) >> bpa_pkg::OFS_W);
    assign in_end   = {{(bpa_pkg::NPG_W+1-PW){1'b0}}, i_address[bpa_pkg::ADDR_W-1 -: PW]}
                      + {1'b0, in_pages};

    // Build the bit mask for the current word of the marked range
    assign last_page = PW'({1'b0, r_base} + r_pages[PW:0] - 1'b1);
    always_comb begin
        lo_bit = (r_word == r_base[PW-1:bpa_pkg::BIT_W])
                 ? {1'b0, r_base[bpa_pkg::BIT_W-1:0]} : '0;
        hi_bit = (r_word == last_page[PW-1:bpa_pkg::BIT_W])
                 ? {1'b0, last_page[bpa_pkg::BIT_W-1:0]} + 1'b1
                 : (bpa_pkg::BIT_W+1)'(bpa_pkg::WORD_BITS);
        for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
            mark_mask[b] = ((bpa_pkg::BIT_W+1)'(b) >= lo_bit)
                           && ((bpa_pkg::BIT_W+1)'(b) < hi_bit);
        end
    end

    // Hold state, counts and the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpa_pkg::S_IDLE;
            r_free      <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_used      <= n_used;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_apply      <= n_apply;
        r_pages      <= n_pages;
        r_base       <= n_base;
        r_word       <= n_word;
        r_chunk      <= n_chunk;
        r_run        <= n_run;
        r_start      <= n_start;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    // Sequence the request: scan (allocate only), mark, then load the result beat
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_status     = r_status;
        n_apply      = r_apply;
        n_pages      = r_pages;
        n_base       = r_base;
        n_word       = r_word;
        n_chunk      = r_chunk;
        n_run        = r_run;
        n_start      = r_start;
        n_free       = r_free;
        n_used       = r_used;
        n_total      = r_total;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        map_req      = '0;
        map_req.addr = r_word;
        o_in_ready   = 1'b0;

        case (r_state)
            bpa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = bpa_pkg::t_opcode'(i_opcode);
                    n_pages  = in_pages;
                    n_base   = i_address[bpa_pkg::ADDR_W-1 -: PW];
                    n_apply  = 1'b0;
                    n_status = bpa_pkg::ST_OK;
                    n_run    = '0;
                    n_start  = '0;
                    n_chunk  = '0;
                    if (bpa_pkg::t_opcode'(i_opcode) == bpa_pkg::OP_ALLOC) begin
                        n_word  = '0;
                        n_state = (in_pages == '0) ? bpa_pkg::S_DONE : bpa_pkg::S_SCAN_RD;
                    end else if (in_end > (bpa_pkg::NPG_W+1)'(bpa_pkg::PAGES)) begin
                        n_status = bpa_pkg::ST_BOUNDS;
                        n_state  = bpa_pkg::S_DONE;
                    end else begin
                        if (bpa_pkg::t_opcode'(i_opcode) != bpa_pkg::OP_RESERVE
                            && i_address[bpa_pkg::OFS_W-1:0] != '0) begin
                            n_status = bpa_pkg::ST_MISALIGNED;
                        end
                        n_word  = i_address[bpa_pkg::ADDR_W-1 -: bpa_pkg::WORD_AW];
                        n_start = i_address[bpa_pkg::ADDR_W-1 -: PW];
                        n_state = (in_pages == '0) ? bpa_pkg::S_DONE : bpa_pkg::S_MARK_RD;
                    end
                end
            end
            bpa_pkg::S_SCAN_RD: begin
                map_req.rd_en = 1'b1;
                n_state       = bpa_pkg::S_SCAN;
            end
            bpa_pkg::S_SCAN: begin
                n_run   = scan_run;
                n_start = scan_start;
                n_chunk = r_chunk + 1'b1;
                if (scan_found) begin
                    n_base  = scan_start;
                    n_word  = scan_start[PW-1:bpa_pkg::BIT_W];
                    n_state = bpa_pkg::S_MARK_RD;
                end else if (r_chunk == '1) begin
                    n_word = r_word + 1'b1;
                    if (r_word == '1) begin
                        n_status = bpa_pkg::ST_NO_RUN;
                        n_start  = '0;
                        n_state  = bpa_pkg::S_DONE;
                    end else begin
                        n_state = bpa_pkg::S_SCAN_RD;
                    end
                end
            end
            bpa_pkg::S_MARK_RD: begin
                map_req.rd_en = 1'b1;
                n_state       = bpa_pkg::S_MARK_WR;
            end
            bpa_pkg::S_MARK_WR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_data = (r_op == bpa_pkg::OP_FREE || r_op == bpa_pkg::OP_ADD)
                                  ? (rd_word & ~mark_mask) : (rd_word | mark_mask);
                n_word = r_word + 1'b1;
                if (r_word == last_page[PW-1:bpa_pkg::BIT_W]) begin
                    n_apply = 1'b1;
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    n_state = bpa_pkg::S_MARK_RD;
                end
            end
            bpa_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_apply) begin
                        case (r_op)
                            bpa_pkg::OP_ALLOC: begin
                                n_free = bpa_pkg::sat_sub(r_free, r_pages);
                                n_used = bpa_pkg::sat_add(r_used, r_pages);
                            end
                            bpa_pkg::OP_FREE: begin
                                n_free = bpa_pkg::sat_add(r_free, r_pages);
                                n_used = bpa_pkg::sat_sub(r_used, r_pages);
                            end
                            bpa_pkg::OP_ADD: begin
                                n_free  = bpa_pkg::sat_add(r_free, r_pages);
                                n_total = bpa_pkg::sat_add(r_total, r_pages);
                            end
                            default: begin
                            end
                        endcase
                    end
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = (r_op == bpa_pkg::OP_ALLOC && r_apply)
                                   ? bpa_pkg::ADDR_W'({r_base, {bpa_pkg::OFS_W{1'b0}}})
                                   : '0;
                    n_state      = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;
    assign o_free_pages     = r_free;
    assign o_used_pages     = r_used;
    assign o_total_pages    = r_total;

endmodule
`default_nettype wire
